// ===== src/sep_pkg.sv =====
// Shared types, character codes and field-name tables for the event stream parser.
`default_nettype none

package sep_pkg;

    typedef enum logic [3:0] {
        KIND_DATA     = 4'd0,
        KIND_SEP      = 4'd1,
        KIND_CLEAR    = 4'd2,
        KIND_EBYTE    = 4'd3,
        KIND_IBYTE    = 4'd4,
        KIND_ACCEPT   = 4'd5,
        KIND_REJECT   = 4'd6,
        KIND_DISPATCH = 4'd7,
        KIND_DROPPED  = 4'd8
    } kind_t;

    typedef enum logic [1:0] {
        PH_NAME  = 2'd0,
        PH_COLON = 2'd1,
        PH_VALUE = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        TG_SKIP  = 2'd0,
        TG_DATA  = 2'd1,
        TG_EVENT = 2'd2,
        TG_ID    = 2'd3
    } target_t;

    // Candidate field names, one bit each in the viable mask.
    localparam logic [1:0] CAND_DATA  = 2'd0;
    localparam logic [1:0] CAND_EVENT = 2'd1;
    localparam logic [1:0] CAND_ID    = 2'd2;
    localparam int         NUM_CAND   = 3;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [2:0] NAME_LEN_MAX = 3'd7;

    // Depth of the result queue; a request never yields more than two results.
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic logic [2:0] cand_len(input logic [1:0] k);
        logic [2:0] len;
        unique case (k)
            CAND_DATA:  len = 3'd4;
            CAND_EVENT: len = 3'd5;
            CAND_ID:    len = 3'd2;
            default:    len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] cand_char(input logic [1:0] k, input logic [2:0] pos);
        logic [7:0] c;
        c = CH_NUL;
        unique case (k)
            CAND_DATA:
            begin
                unique case (pos)
                    3'd0:    c = "d";
                    3'd1:    c = "a";
                    3'd2:    c = "t";
                    3'd3:    c = "a";
                    default: c = CH_NUL;
                endcase
            end
            CAND_EVENT:
            begin
                unique case (pos)
                    3'd0:    c = "e";
                    3'd1:    c = "v";
                    3'd2:    c = "e";
                    3'd3:    c = "n";
                    3'd4:    c = "t";
                    default: c = CH_NUL;
                endcase
            end
            CAND_ID:
            begin
                unique case (pos)
                    3'd0:    c = "i";
                    3'd1:    c = "d";
                    default: c = CH_NUL;
                endcase
            end
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== src/sse_event_stream_parser.sv =====
// Top level of the server-sent events line parser.
//
// Requests arrive on the input channel (in_valid/in_ready) as one raw stream
// byte in byte_in, or as an end-of-input mark when end_of_input is high.
// Results leave on the output channel (out_valid/out_ready) as kind, value
// and last; last marks the final result caused by one request.
// A request is parsed in the cycle it is accepted and its results sit in a
// four-entry result queue, so with an empty queue the first result is
// offered in the cycle after acceptance. One request is accepted per cycle
// as long as each gives at most one result and the receiver keeps up; an
// end of input whose open field has a pending result gives two results.
// A name byte or the LF of a CRLF pair gives no result. in_ready is high
// while the queue has at least two free entries, so a stalled receiver
// backs up into the input once more than two results are held.
// Reset clears the parser to the start of a line with no event pending and
// empties the queue.
`default_nettype none

module sse_event_stream_parser
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] byte_in,
    input  wire logic       end_of_input,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [3:0]      kind,
    output logic [7:0]      value,
    output logic            last
);

    sep_pkg::push_t   push;
    sep_pkg::result_t head;
    logic             accept;
    logic             has_room;

    assign in_ready = has_room;
    assign accept   = in_valid && has_room;

    sep_core u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .byte_in      (byte_in),
        .end_of_input (end_of_input),
        .push         (push)
    );

    sep_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (out_valid && out_ready),
        .has_room  (has_room),
        .not_empty (out_valid),
        .head      (head)
    );

    assign kind  = head.kind;
    assign value = head.value;
    assign last  = head.last;

endmodule

`default_nettype wire

// ===== src/sep_core.sv =====
// Parser state and the per-byte decision logic that produces up to two results.
`default_nettype none

module sep_core
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [7:0]    byte_in,
    input  wire logic          end_of_input,
    output sep_pkg::push_t     push
);

    sep_pkg::phase_t  phase_reg, phase_next;
    sep_pkg::target_t target_reg, target_next;
    logic [2:0]       viable_reg, viable_next;
    logic [2:0]       len_reg, len_next;
    logic             have_data_reg, have_data_next;
    logic             nonempty_reg, nonempty_next;
    logic             nul_reg, nul_next;
    logic             pending_cr_reg, pending_cr_next;

    sep_pkg::target_t matched;
    logic             is_eol;
    logic             pre_valid;
    sep_pkg::kind_t   pre_kind;
    logic [7:0]       pre_value;

    assign is_eol = (byte_in == sep_pkg::CH_CR) || (byte_in == sep_pkg::CH_LF);

    // The first candidate whose full name was seen decides the field.
    always_comb
    begin
        if (viable_reg[sep_pkg::CAND_DATA] && (len_reg == sep_pkg::cand_len(sep_pkg::CAND_DATA)))
            matched = sep_pkg::TG_DATA;
        else if (viable_reg[sep_pkg::CAND_EVENT]
                 && (len_reg == sep_pkg::cand_len(sep_pkg::CAND_EVENT)))
            matched = sep_pkg::TG_EVENT;
        else if (viable_reg[sep_pkg::CAND_ID] && (len_reg == sep_pkg::cand_len(sep_pkg::CAND_ID)))
            matched = sep_pkg::TG_ID;
        else
            matched = sep_pkg::TG_SKIP;
    end

    always_comb
    begin
        phase_next      = phase_reg;
        target_next     = target_reg;
        viable_next     = viable_reg;
        len_next        = len_reg;
        have_data_next  = have_data_reg;
        nonempty_next   = nonempty_reg;
        nul_next        = nul_reg;
        pending_cr_next = pending_cr_reg;
        pre_valid       = 1'b0;
        pre_kind        = sep_pkg::KIND_DATA;
        pre_value       = 8'h00;

        if (end_of_input)
        begin
            // Finish whatever field is open, then the parser starts over.
            if (phase_reg == sep_pkg::PH_NAME)
            begin
                if (len_reg != 3'd0)
                begin
                    unique case (matched)
                        sep_pkg::TG_DATA:
                        begin
                            pre_valid = nonempty_reg;
                            pre_kind  = sep_pkg::KIND_SEP;
                        end
                        sep_pkg::TG_EVENT:
                        begin
                            pre_valid = 1'b1;
                            pre_kind  = sep_pkg::KIND_CLEAR;
                        end
                        sep_pkg::TG_ID:
                        begin
                            pre_valid = 1'b1;
                            pre_kind  = sep_pkg::KIND_ACCEPT;
                        end
                        default:
                        begin
                            pre_valid = 1'b0;
                        end
                    endcase
                end
            end
            else if (target_reg == sep_pkg::TG_ID)
            begin
                pre_valid = 1'b1;
                pre_kind  = nul_reg ? sep_pkg::KIND_REJECT : sep_pkg::KIND_ACCEPT;
            end
            phase_next      = sep_pkg::PH_NAME;
            target_next     = sep_pkg::TG_SKIP;
            viable_next     = 3'b111;
            len_next        = 3'd0;
            have_data_next  = 1'b0;
            nonempty_next   = 1'b0;
            nul_next        = 1'b0;
            pending_cr_next = 1'b0;
        end
        else if (pending_cr_reg && (byte_in == sep_pkg::CH_LF))
        begin
            // Second half of a CRLF line end.
            pending_cr_next = 1'b0;
        end
        else
        begin
            pending_cr_next = 1'b0;
            if (phase_reg == sep_pkg::PH_NAME)
            begin
                if (is_eol)
                begin
                    if (len_reg == 3'd0)
                    begin
                        pre_valid = 1'b1;
                        if (have_data_reg)
                        begin
                            pre_kind       = sep_pkg::KIND_DISPATCH;
                            have_data_next = 1'b0;
                            nonempty_next  = 1'b0;
                        end
                        else
                        begin
                            pre_kind = sep_pkg::KIND_CLEAR;
                        end
                    end
                    else
                    begin
                        // A bare name acts as that field with an empty value.
                        unique case (matched)
                            sep_pkg::TG_DATA:
                            begin
                                have_data_next = 1'b1;
                                pre_valid      = nonempty_reg;
                                pre_kind       = sep_pkg::KIND_SEP;
                            end
                            sep_pkg::TG_EVENT:
                            begin
                                pre_valid = 1'b1;
                                pre_kind  = sep_pkg::KIND_CLEAR;
                            end
                            sep_pkg::TG_ID:
                            begin
                                pre_valid = 1'b1;
                                pre_kind  = sep_pkg::KIND_ACCEPT;
                            end
                            default:
                            begin
                                pre_valid = 1'b0;
                            end
                        endcase
                    end
                    phase_next      = sep_pkg::PH_NAME;
                    target_next     = sep_pkg::TG_SKIP;
                    viable_next     = 3'b111;
                    len_next        = 3'd0;
                    nul_next        = 1'b0;
                    pending_cr_next = (byte_in == sep_pkg::CH_CR);
                end
                else if (byte_in == sep_pkg::CH_COLON)
                begin
                    if (len_reg == 3'd0)
                    begin
                        target_next = sep_pkg::TG_SKIP;
                        phase_next  = sep_pkg::PH_VALUE;
                    end
                    else
                    begin
                        target_next = matched;
                        phase_next  = sep_pkg::PH_COLON;
                        unique case (matched)
                            sep_pkg::TG_DATA:
                            begin
                                have_data_next = 1'b1;
                                pre_valid      = nonempty_reg;
                                pre_kind       = sep_pkg::KIND_SEP;
                            end
                            sep_pkg::TG_EVENT:
                            begin
                                pre_valid = 1'b1;
                                pre_kind  = sep_pkg::KIND_CLEAR;
                            end
                            sep_pkg::TG_ID:
                            begin
                                nul_next = 1'b0;
                            end
                            default:
                            begin
                                pre_valid = 1'b0;
                            end
                        endcase
                    end
                end
                else
                begin
                    for (int k = 0; k < sep_pkg::NUM_CAND; k++)
                    begin
                        if (!((len_reg < sep_pkg::cand_len(2'(k)))
                              && (sep_pkg::cand_char(2'(k), len_reg) == byte_in)))
                            viable_next[k] = 1'b0;
                    end
                    if (len_reg != sep_pkg::NAME_LEN_MAX)
                        len_next = len_reg + 3'd1;
                end
            end
            else if ((phase_reg == sep_pkg::PH_COLON) && (byte_in == sep_pkg::CH_SPACE))
            begin
                phase_next = sep_pkg::PH_VALUE;
            end
            else
            begin
                phase_next = sep_pkg::PH_VALUE;
                if (is_eol)
                begin
                    if (target_reg == sep_pkg::TG_ID)
                    begin
                        pre_valid = 1'b1;
                        pre_kind  = nul_reg ? sep_pkg::KIND_REJECT : sep_pkg::KIND_ACCEPT;
                    end
                    phase_next      = sep_pkg::PH_NAME;
                    target_next     = sep_pkg::TG_SKIP;
                    viable_next     = 3'b111;
                    len_next        = 3'd0;
                    nul_next        = 1'b0;
                    pending_cr_next = (byte_in == sep_pkg::CH_CR);
                end
                else
                begin
                    unique case (target_reg)
                        sep_pkg::TG_DATA:
                        begin
                            pre_valid     = 1'b1;
                            pre_kind      = sep_pkg::KIND_DATA;
                            pre_value     = byte_in;
                            nonempty_next = 1'b1;
                        end
                        sep_pkg::TG_EVENT:
                        begin
                            pre_valid = 1'b1;
                            pre_kind  = sep_pkg::KIND_EBYTE;
                            pre_value = byte_in;
                        end
                        sep_pkg::TG_ID:
                        begin
                            pre_valid = 1'b1;
                            pre_kind  = sep_pkg::KIND_IBYTE;
                            pre_value = byte_in;
                            if (byte_in == sep_pkg::CH_NUL)
                                nul_next = 1'b1;
                        end
                        default:
                        begin
                            pre_valid = 1'b0;
                        end
                    endcase
                end
            end
        end
    end

    // End of input always appends a dropped mark after any pending field result.
    always_comb
    begin
        push.first.kind   = pre_kind;
        push.first.value  = pre_value;
        push.first.last   = 1'b1;
        push.second.kind  = sep_pkg::KIND_DROPPED;
        push.second.value = 8'h00;
        push.second.last  = 1'b1;
        if (!accept)
        begin
            push.count = 2'd0;
        end
        else if (end_of_input)
        begin
            if (pre_valid)
            begin
                push.count      = 2'd2;
                push.first.last = 1'b0;
            end
            else
            begin
                push.count       = 2'd1;
                push.first.kind  = sep_pkg::KIND_DROPPED;
                push.first.value = 8'h00;
            end
        end
        else
        begin
            push.count = {1'b0, pre_valid};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= sep_pkg::PH_NAME;
            target_reg     <= sep_pkg::TG_SKIP;
            viable_reg     <= 3'b111;
            len_reg        <= 3'd0;
            have_data_reg  <= 1'b0;
            nonempty_reg   <= 1'b0;
            nul_reg        <= 1'b0;
            pending_cr_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            target_reg     <= target_next;
            viable_reg     <= viable_next;
            len_reg        <= len_next;
            have_data_reg  <= have_data_next;
            nonempty_reg   <= nonempty_next;
            nul_reg        <= nul_next;
            pending_cr_reg <= pending_cr_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/sep_queue.sv =====
// Small result queue that takes up to two results per cycle and hands out one.
`default_nettype none

module sep_queue
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire sep_pkg::push_t push,
    input  wire logic          pop,
    output logic               has_room,
    output logic               not_empty,
    output sep_pkg::result_t   head
);

    sep_pkg::result_t                 entry_reg [sep_pkg::QUEUE_DEPTH];
    logic [sep_pkg::PTR_W-1:0]        wr_ptr_reg, rd_ptr_reg;
    logic [sep_pkg::COUNT_W-1:0]      count_reg, count_next;
    logic [sep_pkg::PTR_W-1:0]        wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + sep_pkg::PTR_W'(1);
    assign not_empty    = (count_reg != '0);
    assign head         = entry_reg[rd_ptr_reg];

    // Room is kept for the worst case of two results from one request.
    assign has_room = (count_reg <= sep_pkg::COUNT_W'(sep_pkg::QUEUE_DEPTH - 2));

    assign count_next = count_reg + sep_pkg::COUNT_W'(push.count)
                        - sep_pkg::COUNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_reg + sep_pkg::PTR_W'(push.count);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + sep_pkg::PTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            entry_reg[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            entry_reg[wr_ptr_plus1] <= push.second;
    end

endmodule

`default_nettype wire
